FILE: hdl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants for the Sobel gradient magnitude stream.
// ----------------------------------------------------------------------------
`default_nettype none
package sgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_DEPTH = 4 * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int DIM_W      = 11;
  localparam int POS_W      = 10;
  localparam int MIN_DIM    = 5;

  localparam logic [1:0] REG_KERNEL_MODE  = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_RD, S_RDL, S_PART, S_SUM, S_BIAS, S_SQ, S_SQRT, S_OUT
  } state_t;

  typedef struct packed {
    logic       start;
    logic       pos;
    logic [1:0] rd_k;
    logic       cap;
    logic       shift;
    logic       part;
    logic       sum;
    logic       bias;
    logic       sq;
    logic       sqrt_step;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/sgm_ram.sv
// ----------------------------------------------------------------------------
// sgm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/sgm_ctrl.sv
// ----------------------------------------------------------------------------
// sgm_ctrl
// Sequencer: steps one request through read, window, sum, divide and root.
// ----------------------------------------------------------------------------
`default_nettype none
module sgm_ctrl import sgm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_POS;
      S_POS: begin
        state_nxt = S_RD;
        cnt_nxt   = '0;
      end
      S_RD: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) state_nxt = S_RDL;
      end
      S_RDL:  state_nxt = sts.emit ? S_PART : S_IDLE;
      S_PART: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_BIAS;
      S_BIAS: state_nxt = S_SQ;
      S_SQ: begin
        state_nxt = S_SQRT;
        cnt_nxt   = '0;
      end
      S_SQRT: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) state_nxt = S_OUT;
      end
      S_OUT:   if (!sts.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd           = '0;
    cmd.start     = (state_r == S_IDLE) && in_valid;
    cmd.pos       = (state_r == S_POS);
    cmd.rd_k      = cnt_r[1:0];
    cmd.cap       = (state_r == S_RD) && (cnt_r != 3'd0);
    cmd.shift     = (state_r == S_RDL);
    cmd.part      = (state_r == S_PART);
    cmd.sum       = (state_r == S_SUM);
    cmd.bias      = (state_r == S_BIAS);
    cmd.sq        = (state_r == S_SQ);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.load      = (state_r == S_OUT) && !sts.out_busy;
  end

endmodule
`default_nettype wire

FILE: hdl/sgm_dp.sv
// ----------------------------------------------------------------------------
// sgm_dp
// Datapath: position tracking, line store, window, gradients and root.
// ----------------------------------------------------------------------------
`default_nettype none
module sgm_dp import sgm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_addr,
  input  wire logic [DIM_W-1:0] cfg_wdata,
  input  wire logic             in_op,
  input  wire logic [7:0]       in_pixel,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [7:0]       out_grad_x,
  output logic      [7:0]       out_grad_y,
  output logic      [7:0]       out_magnitude,
  output logic      [POS_W-1:0] out_row,
  output logic      [POS_W-1:0] out_col,
  output logic                  out_frame_last
);

  logic             mode_r;
  logic [DIM_W-1:0] fw_r, fh_r, w_c, h_c, rad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      fw_r   <= DIM_W'(500);
      fh_r   <= DIM_W'(312);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KERNEL_MODE:  mode_r <= cfg_wdata[0];
        REG_FRAME_WIDTH:  fw_r   <= cfg_wdata;
        REG_FRAME_HEIGHT: fh_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = fw_r;
    if (fw_r < DIM_W'(MIN_DIM)) w_c = DIM_W'(MIN_DIM);
    if (fw_r > DIM_W'(MAX_WIDTH)) w_c = DIM_W'(MAX_WIDTH);
    h_c = fh_r;
    if (fh_r < DIM_W'(MIN_DIM)) h_c = DIM_W'(MIN_DIM);
    if (fh_r > DIM_W'(MAX_HEIGHT)) h_c = DIM_W'(MAX_HEIGHT);
    rad = mode_r ? DIM_W'(2) : DIM_W'(1);
  end

  // position of the incoming pixel and of the delayed result pixel
  logic [POS_W-1:0] in_col_r, in_row_r, col_r, row_r, qr_r, qc_r;
  logic             primed_r, emit_r;
  logic [7:0]       pix_r;
  logic [DIM_W-1:0] c0, r0, qc_c, qr_c, rsub;
  logic             borrow, wrap;

  always_comb begin
    c0 = {1'b0, in_col_r};
    r0 = {1'b0, in_row_r};
    if (c0 >= w_c) begin
      c0 = '0;
      r0 = r0 + DIM_W'(1);
    end
    if (r0 >= h_c) r0 = '0;
    borrow = (c0 < rad);
    qc_c   = borrow ? c0 + w_c - rad : c0 - rad;
    rsub   = r0 - rad - DIM_W'(borrow);
    wrap   = (r0 < rad + DIM_W'(borrow));
    qr_c   = wrap ? rsub + h_c : rsub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      primed_r <= 1'b0;
      emit_r   <= 1'b0;
    end else if (cmd.pos) begin
      emit_r <= primed_r | ~wrap;
      if (!wrap) primed_r <= 1'b1;
      if (c0 + DIM_W'(1) >= w_c) begin
        in_col_r <= '0;
        in_row_r <= (r0 + DIM_W'(1) >= h_c) ? '0 : POS_W'(r0 + DIM_W'(1));
      end else begin
        in_col_r <= POS_W'(c0 + DIM_W'(1));
        in_row_r <= POS_W'(r0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) pix_r <= in_op ? 8'd0 : in_pixel;
    if (cmd.pos) begin
      col_r <= POS_W'(c0);
      row_r <= POS_W'(r0);
      qc_r  <= POS_W'(qc_c);
      qr_r  <= POS_W'(qr_c);
    end
  end

  // line store: four rows, read one slot per cycle, write the new pixel last
  logic [7:0]        rdata;
  logic [1:0]        rslot;
  logic [ADDR_W-1:0] raddr, waddr;

  assign rslot = cmd.rd_k + row_r[1:0];
  assign raddr = {rslot, col_r[COL_W-1:0]};
  assign waddr = {row_r[1:0], col_r[COL_W-1:0]};

  sgm_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (waddr),
    .wdata (pix_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic [7:0] colbuf_r [3];
  logic [7:0] win_r    [5][5];
  logic [7:0] column   [5];

  always_comb begin
    column[0] = colbuf_r[0];
    column[1] = colbuf_r[1];
    column[2] = colbuf_r[2];
    column[3] = rdata;
    column[4] = pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 5; c++) begin
          win_r[r][c] <= 8'd0;
        end
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
        win_r[r][4] <= column[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) colbuf_r[cmd.rd_k - 2'd1] <= rdata;
  end

  // row and column partial sums
  logic signed [11:0] rx_r [5];
  logic signed [11:0] ry_r [5];
  logic signed [11:0] v    [5][5];

  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        v[r][c] = $signed({4'd0, win_r[r][c]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.part) begin
      for (int i = 0; i < 5; i++) begin
        if (mode_r) begin
          ry_r[i] <= v[i][4] + (v[i][3] <<< 1) - (v[i][1] <<< 1) - v[i][0];
          rx_r[i] <= v[4][i] + (v[3][i] <<< 1) - (v[1][i] <<< 1) - v[0][i];
        end else if (i >= 2) begin
          ry_r[i] <= v[i][2] - v[i][4];
          rx_r[i] <= v[2][i] - v[4][i];
        end else begin
          ry_r[i] <= '0;
          rx_r[i] <= '0;
        end
      end
    end
  end

  logic signed [15:0] sx_r, sy_r;
  logic signed [15:0] ex [5];
  logic signed [15:0] ey [5];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      ex[i] = 16'(rx_r[i]);
      ey[i] = 16'(ry_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      if (mode_r) begin
        sx_r <= ex[0] + (ex[1] <<< 1) + (ex[2] <<< 2) + (ex[3] <<< 1) + ex[4];
        sy_r <= ey[0] + (ey[1] <<< 1) + (ey[2] <<< 2) + (ey[3] <<< 1) + ey[4];
      end else begin
        sx_r <= ex[2] + (ex[3] <<< 1) + ex[4];
        sy_r <= ey[2] + (ey[3] <<< 1) + ey[4];
      end
    end
  end

  // bias, divide by 4 or 10 (reciprocal 52429 / 2^19), saturate
  function automatic logic [7:0] bias_sat(logic signed [15:0] s, logic m);
    logic signed [16:0] t;
    logic [27:0]        prod;
    logic [7:0]         g;
    t    = 17'(s) + (m ? 17'sd1280 : 17'sd512);
    prod = 28'(t[11:0]) * 28'd52429;
    if (t < 0) g = 8'd0;
    else if (!m) g = (t >= 17'sd1024) ? 8'd255 : t[9:2];
    else g = (t >= 17'sd2560) ? 8'd255 : prod[26:19];
    return g;
  endfunction

  logic [7:0] gx_r, gy_r;
  logic       inner;

  assign inner = ({1'b0, qr_r} >= rad) && ({1'b0, qr_r} + rad <= h_c - DIM_W'(1)) &&
                 ({1'b0, qc_r} >= rad) && ({1'b0, qc_r} + rad <= w_c - DIM_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.bias) begin
      gx_r <= inner ? bias_sat(sx_r, mode_r) : 8'd0;
      gy_r <= inner ? bias_sat(sy_r, mode_r) : 8'd0;
    end
  end

  // squares, then bit-pair integer root
  logic signed [8:0]  ux, uy;
  logic signed [17:0] px, py;
  logic [15:0]        sq_r, res_r, bit_r;
  logic [16:0]        trial;

  assign ux    = $signed({1'b0, gx_r}) - 9'sd128;
  assign uy    = $signed({1'b0, gy_r}) - 9'sd128;
  assign px    = ux * ux;
  assign py    = uy * uy;
  assign trial = {1'b0, res_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sq_r  <= 16'(px + py);
      res_r <= '0;
      bit_r <= 16'h4000;
    end else if (cmd.sqrt_step) begin
      if ({1'b0, sq_r} >= trial) begin
        sq_r  <= 16'({1'b0, sq_r} - trial);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_grad_x     <= gx_r;
      out_grad_y     <= gy_r;
      out_magnitude  <= res_r[7:0];
      out_row        <= qr_r;
      out_col        <= qc_r;
      out_frame_last <= ({1'b0, qr_r} == h_c - DIM_W'(1)) &&
                        ({1'b0, qc_r} == w_c - DIM_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign sts       = '{emit: emit_r, out_busy: out_valid_r && !out_ready};

endmodule
`default_nettype wire

FILE: hdl/sobel_gradient_magnitude_stream.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_stream
// 3x3 / 5x5 Sobel gradients and magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// A new pixel is accepted only after the previous one is finished and its result,
// if any, is in the output register, which waits while a held result stalls; the
// pace is set by four line-store reads on one RAM port and the eight-step root.
// Reset: synchronous, active low; window, position and output valid cleared,
// configuration reset to its defaults, line store contents undefined until written.
`default_nettype none
module sobel_gradient_magnitude_stream import sgm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_addr,
  input  wire logic [DIM_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_op,
  input  wire logic [7:0]       in_pixel,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [7:0]       out_grad_x,
  output logic      [7:0]       out_grad_y,
  output logic      [7:0]       out_magnitude,
  output logic      [POS_W-1:0] out_row,
  output logic      [POS_W-1:0] out_col,
  output logic                  out_frame_last
);

  cmd_t cmd;
  sts_t sts;

  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_pixel       (in_pixel),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_magnitude  (out_magnitude),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Sobel gradient magnitude stream: a line-buffer
// and window predictor computes the expected gradients, magnitude and
// position for every accepted request that yields a result, and the result stream is checked
// field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sgm_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         LAT_IDLE   = 40;
  localparam int         FILL_WIDTH = 32;

  typedef struct {
    logic       op;
    logic [7:0] pixel;
  } pix_req_t;

  typedef struct {
    logic [7:0]       gx;
    logic [7:0]       gy;
    logic [7:0]       mag;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } grad_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_addr = REG_KERNEL_MODE;
  logic [DIM_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_op = 1'b0;
  logic [7:0]       in_pixel = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_grad_x, out_grad_y, out_magnitude;
  logic [POS_W-1:0] out_row, out_col;
  logic             out_frame_last;

  sobel_gradient_magnitude_stream DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  line_mem [LINE_DEPTH];
  logic [7:0]  win [5][5];
  int unsigned pos_row, pos_col;
  bit          primed;
  bit          mode;
  int unsigned width_reg, height_reg;

  pix_req_t  pending_pix [$];
  grad_res_t expected_grad [$];
  int        errors = 0;
  int        send_idle_max = 13;
  int        recv_idle_max = 13;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        long_hold = 0;
  int        results_seen = 0;

  function automatic int k3(int i, int j);
    int t [3][3] = '{'{1, 0, -1}, '{2, 0, -2}, '{1, 0, -1}};
    return t[i][j];
  endfunction

  function automatic int k5(int i, int j);
    int t [5][5] = '{'{-1, -2, 0, 2, 1}, '{-2, -4, 0, 4, 2}, '{-4, -8, 0, 8, 4},
                     '{-2, -4, 0, 4, 2}, '{-1, -2, 0, 2, 1}};
    return t[i][j];
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int biased_grad(int sum, int d);
    int t;
    t = sum + 128 * d;
    if (t < 0) return 0;
    t = t / d;
    return (t > 255) ? 255 : t;
  endfunction

  function automatic int root_floor(int v);
    int m;
    m = 0;
    while ((m + 1) * (m + 1) <= v) m++;
    return m;
  endfunction

  task automatic apply_reg(logic [1:0] idx, int unsigned val);
    case (idx)
      REG_KERNEL_MODE:  mode = val[0];
      REG_FRAME_WIDTH:  width_reg = val & 'h7FF;
      REG_FRAME_HEIGHT: height_reg = val & 'h7FF;
      default: ;
    endcase
  endtask

  // Advance the window by one pixel and queue the delayed result, if any.
  task automatic predict_gradient(pix_req_t r);
    int unsigned w, h, rad, row, col, p, n, dly, q, qr, qc;
    logic [7:0]  column [5];
    logic [7:0]  pix;
    int          sx, sy, gx, gy, ux, uy, v;
    grad_res_t   e;
    bit          emit;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    rad = mode ? 2 : 1;
    pix = r.op ? 8'd0 : r.pixel;
    sx = 0;
    sy = 0;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    col = pos_col;
    row = pos_row;
    for (int k = 0; k < 4; k++) column[k] = line_mem[((row + k) & 3) * MAX_WIDTH + col];
    column[4] = pix;
    for (int a = 0; a < 5; a++) begin
      for (int b = 0; b < 4; b++) win[a][b] = win[a][b+1];
      win[a][4] = column[a];
    end
    line_mem[(row & 3) * MAX_WIDTH + col] = pix;
    p = row * w + col;
    n = h * w;
    dly = rad * w + rad;
    emit = primed || p >= dly;
    if (p >= dly) primed = 1;
    q = (p >= dly) ? p - dly : p + n - dly;
    qr = q / w;
    qc = q % w;
    if (col + 1 >= w) begin
      pos_col = 0;
      pos_row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      pos_col = col + 1;
    end
    if (!emit) return;
    if (qr >= rad && qr + rad <= h - 1 && qc >= rad && qc + rad <= w - 1) begin
      if (mode) begin
        for (int a = 0; a < 5; a++)
          for (int b = 0; b < 5; b++) begin
            v = win[a][b];
            sx += v * k5(b, a);
            sy += v * k5(a, b);
          end
        gx = biased_grad(sx, 10);
        gy = biased_grad(sy, 10);
      end else begin
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) begin
            v = win[2+a][2+b];
            sx += v * k3(b, a);
            sy += v * k3(a, b);
          end
        gx = biased_grad(sx, 4);
        gy = biased_grad(sy, 4);
      end
    end else begin
      gx = 0;
      gy = 0;
    end
    ux = gx - 128;
    uy = gy - 128;
    e.gx = gx[7:0];
    e.gy = gy[7:0];
    e.mag = 8'(root_floor(ux * ux + uy * uy));
    e.row = qr[POS_W-1:0];
    e.col = qc[POS_W-1:0];
    e.last = (q == n - 1);
    expected_grad.push_back(e);
  endtask

  // driver
  always @(posedge clk) begin
    pix_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_gradient('{op: in_op, pixel: in_pixel});
      if (in_valid && !in_ready) begin
        // hold the request
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_pix.size() > 0) begin
        r = pending_pix.pop_front();
        in_op <= r.op;
        in_pixel <= r.pixel;
        in_valid <= 1'b1;
        send_gap = $urandom_range(0, send_idle_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grad_res_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_grad.size() == 0) begin
          $error("unexpected result row=%0d col=%0d", out_row, out_col);
          errors++;
        end else begin
          e = expected_grad.pop_front();
          if (out_grad_x !== e.gx) begin
            $error("grad_x expected %0d actual %0d", e.gx, out_grad_x); errors++;
          end
          if (out_grad_y !== e.gy) begin
            $error("grad_y expected %0d actual %0d", e.gy, out_grad_y); errors++;
          end
          if (out_magnitude !== e.mag) begin
            $error("magnitude expected %0d actual %0d", e.mag, out_magnitude); errors++;
          end
          if (out_row !== e.row) begin
            $error("out_row expected %0d actual %0d", e.row, out_row); errors++;
          end
          if (out_col !== e.col) begin
            $error("out_col expected %0d actual %0d", e.col, out_col); errors++;
          end
          if (out_frame_last !== e.last) begin
            $error("frame_last expected %0d actual %0d", e.last, out_frame_last); errors++;
          end
        end
        recv_gap = $urandom_range(0, recv_idle_max);
        // back up the block once, during the fill
        if (results_seen == 60) long_hold = 600;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_pix.size() > 0 || in_valid || expected_grad.size() > 0) @(posedge clk);
    repeat (LAT_IDLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[DIM_W-1:0];
    apply_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pix(logic op, logic [7:0] pixel);
    pix_req_t r;
    r.op = op;
    r.pixel = pixel;
    pending_pix.push_back(r);
  endtask

  function automatic logic [7:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned w, h, extra;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[a, b]) win[a][b] = '0;
    pos_row = 0;
    pos_col = 0;
    primed = 0;
    mode = 0;
    width_reg = 500;
    height_reg = 312;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // fill all four lines across every column used below
    write_reg(REG_KERNEL_MODE, 0);
    write_reg(REG_FRAME_WIDTH, FILL_WIDTH);
    write_reg(REG_FRAME_HEIGHT, MAX_HEIGHT);
    for (int i = 0; i < 4 * FILL_WIDTH; i++) push_pix($urandom_range(0, 7) == 0, rand_pixel());
    wait_drained();

    // directed: smallest frame, hard edges to saturate both gradients
    for (int m = 0; m < 2; m++) begin
      write_reg(REG_KERNEL_MODE, m);
      write_reg(REG_FRAME_WIDTH, MIN_DIM);
      write_reg(REG_FRAME_HEIGHT, MIN_DIM);
      for (int i = 0; i < 25; i++)
        push_pix(i == 7 || i == 18, ((i % 5) < 2 || i < 10) ? 8'hFF : 8'h00);
      wait_drained();
    end
    // clamped dimensions and an ignored register index
    write_reg(REG_FRAME_WIDTH, 'h7FF);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_UNUSED, 'h555);
    for (int i = 0; i < 20; i++) push_pix(i == 3, rand_pixel());
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 'h7FF);
    for (int i = 0; i < 12; i++) push_pix(1'b0, rand_pixel());
    wait_drained();

    // random frames, mostly whole ones
    for (int ph = 0; ph < 4; ph++) begin
      w = $urandom_range(5, 9);
      h = $urandom_range(5, 8);
      send_idle_max = $urandom_range(0, 2) == 0 ? 0 : 13;
      recv_idle_max = $urandom_range(0, 2) == 0 ? 0 : 13;
      write_reg(REG_KERNEL_MODE, $urandom_range(0, 1));
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      extra = $urandom_range(0, 2 * w);
      for (int i = 0; i < w * h + extra; i++)
        push_pix($urandom_range(0, 9) == 0, rand_pixel());
      wait_drained();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
hdl/sgm_pkg.sv
hdl/sgm_ram.sv
hdl/sgm_ctrl.sv
hdl/sgm_dp.sv
hdl/sobel_gradient_magnitude_stream.sv
tb/tb_top.sv
